/* rtl/rlvs_pkg.sv */
// Shared constants, codes and control types of the run-length vector store.
// No dependencies; compiled first.
package rlvs_pkg;

    localparam int unsigned ACT_W           = 2;
    localparam int unsigned DATA_W          = 64;
    localparam int unsigned LEN_W           = 31;
    localparam int unsigned STAT_W          = 2;
    localparam int unsigned MAX_RUNS_DEF    = 64;
    localparam int unsigned VALUE_WIDTH_DEF = 64;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PROJECT = 2'd2;
    localparam logic [ACT_W-1:0] ACT_EXTRACT = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BOUNDS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_RSVD   = 2'd3;

    typedef struct packed {
        logic capture;
        logic do_clear;
        logic do_append;
        logic bad_load;
        logic scan_start;
        logic scan_step;
        logic proj_load;
        logic emit_start;
        logic emit_read;
        logic emit_load;
    } rlvs_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] in_act;
        logic             in_bad;
        logic             hit;
        logic             emit_last;
    } rlvs_stat_t;

endpackage

/* rtl/rlvs_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on rlvs_pkg.
interface rlvs_req_if;
    logic                            valid;
    logic                            ready;
    logic [rlvs_pkg::ACT_W-1:0]      action;
    logic [rlvs_pkg::DATA_W-1:0]     elem_value;
    logic [rlvs_pkg::LEN_W-1:0]      position;
    logic [rlvs_pkg::LEN_W-1:0]      range_end;

    modport source (output valid, action, elem_value, position, range_end, input ready);
    modport sink   (input valid, action, elem_value, position, range_end, output ready);
endinterface

interface rlvs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [rlvs_pkg::DATA_W-1:0]     run_value;
    logic [rlvs_pkg::LEN_W-1:0]      span_len;
    logic [rlvs_pkg::STAT_W-1:0]     status;
    logic                            last;

    modport source (output valid, run_value, span_len, status, last, input ready);
    modport sink   (input valid, run_value, span_len, status, last, output ready);
endinterface

/* rtl/rlvs_datapath.sv */
// Datapath: run memories, counters, scan accumulator, clipping and output register.
// Depends on rlvs_pkg; driven by rlvs_ctrl through rlvs_cmd_t.
module rlvs_datapath #(
    parameter int unsigned MAX_RUNS    = rlvs_pkg::MAX_RUNS_DEF,
    parameter int unsigned VALUE_WIDTH = rlvs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rlvs_pkg::rlvs_cmd_t           cmd,
    output rlvs_pkg::rlvs_stat_t          stat,
    input  logic [rlvs_pkg::ACT_W-1:0]    action,
    input  logic [rlvs_pkg::DATA_W-1:0]   elem_value,
    input  logic [rlvs_pkg::LEN_W-1:0]    position,
    input  logic [rlvs_pkg::LEN_W-1:0]    range_end,
    output logic [rlvs_pkg::DATA_W-1:0]   run_value,
    output logic [rlvs_pkg::LEN_W-1:0]    span_len,
    output logic [rlvs_pkg::STAT_W-1:0]   status,
    output logic                          last
);
    localparam int unsigned AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int unsigned CW = $clog2(MAX_RUNS + 1);
    localparam int unsigned VW = VALUE_WIDTH;
    localparam int unsigned LW = rlvs_pkg::LEN_W;
    localparam logic [CW-1:0] RUNS_FULL = CW'(MAX_RUNS);

    logic [VW-1:0] mem_val [MAX_RUNS];
    logic [LW-1:0] mem_len [MAX_RUNS];

    logic [CW-1:0] run_count_reg;
    logic [LW-1:0] total_reg;
    logic [VW-1:0] last_val_reg;
    logic [LW-1:0] last_len_reg;

    logic [LW-1:0] s_reg, e_reg;
    logic          rev_reg;

    logic [AW-1:0] ptr_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [VW-1:0] rd_val_reg;
    logic [LW-1:0] rd_len_reg;
    logic [LW-1:0] seen_reg;
    logic          found_reg;
    logic [AW-1:0] first_idx_reg;
    logic [LW-1:0] lo_first_reg;
    logic [AW-1:0] last_idx_reg;
    logic [AW-1:0] em_idx_reg;
    logic [LW-1:0] em_pos_reg;

    logic [rlvs_pkg::DATA_W-1:0] out_val_reg;
    logic [LW-1:0]               out_len_reg;
    logic [rlvs_pkg::STAT_W-1:0] out_st_reg;
    logic                        out_last_reg;

    logic [LW-1:0] in_s, in_e;
    logic          in_bad;
    logic [LW-1:0] seen_new;
    logic          hit;
    logic [AW-1:0] first_now;
    logic [LW-1:0] lo_now;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [LW-1:0] lo_e, hi_e, cs, ce, clip;
    logic          emit_last;
    logic [VW-1:0] app_val;
    logic          match, sat, full, app_ok;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] wr_idx;
    logic [LW-1:0] new_len;

    always_comb
    begin
        in_s = (position < range_end) ? position : range_end;
        in_e = (position < range_end) ? range_end : position;
        if (action == rlvs_pkg::ACT_PROJECT)
            in_bad = (position == '0) || (position > total_reg);
        else
            in_bad = (in_s == '0) || (in_e > total_reg);

        seen_new  = seen_reg + rd_len_reg;
        hit       = rd_vld_reg && (seen_new >= e_reg);
        first_now = found_reg ? first_idx_reg : rd_idx_reg;
        lo_now    = found_reg ? lo_first_reg : seen_reg + LW'(1);

        rd_addr = cmd.emit_read ? em_idx_reg : ptr_reg;
        rd_en   = cmd.emit_read || cmd.scan_step;

        lo_e = rev_reg ? em_pos_reg - rd_len_reg + LW'(1) : em_pos_reg;
        hi_e = rev_reg ? em_pos_reg : em_pos_reg + rd_len_reg - LW'(1);
        cs   = (lo_e > s_reg) ? lo_e : s_reg;
        ce   = (hi_e < e_reg) ? hi_e : e_reg;
        clip = ce - cs + LW'(1);
        emit_last = rev_reg ? (em_idx_reg == first_idx_reg) : (em_idx_reg == last_idx_reg);

        app_val = elem_value[VW-1:0];
        match   = (run_count_reg != '0) && (app_val == last_val_reg);
        sat     = (total_reg == rlvs_pkg::LEN_MAX);
        full    = !match && (run_count_reg == RUNS_FULL);
        app_ok  = !sat && !full;
        cnt_m1  = run_count_reg - CW'(1);
        wr_idx  = match ? cnt_m1[AW-1:0] : run_count_reg[AW-1:0];
        new_len = match ? last_len_reg + LW'(1) : LW'(1);
    end

    assign stat.in_act    = action;
    assign stat.in_bad    = in_bad;
    assign stat.hit       = hit;
    assign stat.emit_last = emit_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= '0;
            total_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.do_clear)
            begin
                run_count_reg <= '0;
                total_reg     <= '0;
            end
            else if (cmd.do_append && app_ok)
            begin
                total_reg <= total_reg + LW'(1);
                if (!match)
                    run_count_reg <= run_count_reg + CW'(1);
            end
            if (cmd.scan_start)
            begin
                rd_vld_reg <= 1'b0;
                found_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_vld_reg <= 1'b1;
                if (rd_vld_reg && (seen_new >= s_reg))
                    found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_append && app_ok)
        begin
            mem_val[wr_idx] <= app_val;
            mem_len[wr_idx] <= new_len;
            last_val_reg    <= app_val;
            last_len_reg    <= new_len;
        end
        if (rd_en)
        begin
            rd_val_reg <= mem_val[rd_addr];
            rd_len_reg <= mem_len[rd_addr];
            rd_idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            if (action == rlvs_pkg::ACT_PROJECT)
            begin
                s_reg <= position;
                e_reg <= position;
            end
            else
            begin
                s_reg <= in_s;
                e_reg <= in_e;
            end
            rev_reg <= (position > range_end);
        end
        if (cmd.scan_start)
        begin
            ptr_reg  <= '0;
            seen_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            ptr_reg <= ptr_reg + AW'(1);
            if (rd_vld_reg)
            begin
                seen_reg <= seen_new;
                if (!found_reg && (seen_new >= s_reg))
                begin
                    first_idx_reg <= rd_idx_reg;
                    lo_first_reg  <= seen_reg + LW'(1);
                end
            end
        end
        if (cmd.emit_start)
        begin
            last_idx_reg <= rd_idx_reg;
            em_idx_reg   <= rev_reg ? rd_idx_reg : first_now;
            em_pos_reg   <= rev_reg ? seen_new : lo_now;
        end
        else if (cmd.emit_load)
        begin
            em_idx_reg <= rev_reg ? em_idx_reg - AW'(1) : em_idx_reg + AW'(1);
            em_pos_reg <= rev_reg ? lo_e - LW'(1) : hi_e + LW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_clear)
        begin
            out_val_reg  <= '0;
            out_len_reg  <= '0;
            out_st_reg   <= rlvs_pkg::ST_OK;
            out_last_reg <= 1'b1;
        end
        else if (cmd.do_append)
        begin
            out_val_reg  <= app_ok ? rlvs_pkg::DATA_W'(app_val) : '0;
            out_len_reg  <= app_ok ? new_len : '0;
            out_st_reg   <= app_ok ? rlvs_pkg::ST_OK : rlvs_pkg::ST_FULL;
            out_last_reg <= 1'b1;
        end
        else if (cmd.bad_load)
        begin
            out_val_reg  <= '0;
            out_len_reg  <= '0;
            out_st_reg   <= rlvs_pkg::ST_BOUNDS;
            out_last_reg <= 1'b1;
        end
        else if (cmd.proj_load)
        begin
            out_val_reg  <= rlvs_pkg::DATA_W'(rd_val_reg);
            out_len_reg  <= LW'(1);
            out_st_reg   <= rlvs_pkg::ST_OK;
            out_last_reg <= 1'b1;
        end
        else if (cmd.emit_load)
        begin
            out_val_reg  <= rlvs_pkg::DATA_W'(rd_val_reg);
            out_len_reg  <= clip;
            out_st_reg   <= rlvs_pkg::ST_OK;
            out_last_reg <= emit_last;
        end
    end

    assign run_value  = out_val_reg;
    assign span_len   = out_len_reg;
    assign status     = out_st_reg;
    assign last       = out_last_reg;

endmodule

/* rtl/rlvs_ctrl.sv */
// Controller: sequences accept, scan and emit phases and owns the output valid flag.
// Depends on rlvs_pkg; commands rlvs_datapath.
module rlvs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rlvs_pkg::rlvs_cmd_t   cmd,
    input  rlvs_pkg::rlvs_stat_t  stat
);
    typedef enum logic [1:0] {IDLE, SCAN, EREAD, EDATA} state_t;

    state_t state_reg, state_next;
    logic   out_vld_reg, out_vld_next;
    logic   is_proj_reg, is_proj_next;
    logic   accept, out_free, load;

    always_comb
    begin
        out_free   = !out_vld_reg || out_ready;
        in_ready   = (state_reg == IDLE) && !out_vld_reg;
        accept     = in_valid && in_ready;
        cmd        = '0;
        state_next = state_reg;
        is_proj_next = is_proj_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    cmd.capture  = 1'b1;
                    is_proj_next = (stat.in_act == rlvs_pkg::ACT_PROJECT);
                    case (stat.in_act)
                        rlvs_pkg::ACT_CLEAR:  cmd.do_clear  = 1'b1;
                        rlvs_pkg::ACT_APPEND: cmd.do_append = 1'b1;
                        default:
                        begin
                            if (stat.in_bad)
                                cmd.bad_load = 1'b1;
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = SCAN;
                            end
                        end
                    endcase
                end
            end
            SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    if (is_proj_reg)
                    begin
                        cmd.proj_load = 1'b1;
                        state_next    = IDLE;
                    end
                    else
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = EREAD;
                    end
                end
            end
            EREAD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = EDATA;
            end
            EDATA:
            begin
                if (out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = stat.emit_last ? IDLE : EREAD;
                end
            end
            default: state_next = IDLE;
        endcase
        load = cmd.do_clear || cmd.do_append || cmd.bad_load || cmd.proj_load
               || cmd.emit_load;
        out_vld_next = load ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            out_vld_reg <= 1'b0;
            is_proj_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            is_proj_reg <= is_proj_next;
        end
    end

    assign out_valid = out_vld_reg;

endmodule

/* rtl/run_length_vector_store.sv */
// Run-length vector store: clear, append and out-of-bounds queries answer straight
// from the idle state. Project streams the run-length memory one run per cycle and
// answers once it reaches the run that holds the position. Extract scans the same
// way up to the run holding the larger of position and range end, then reads and
// emits one run at a time, waiting while the response is not taken; the single
// read port serves scan and emit. Run memories need no clearing pass after reset.
module run_length_vector_store #(
    parameter int unsigned MAX_RUNS    = rlvs_pkg::MAX_RUNS_DEF,
    parameter int unsigned VALUE_WIDTH = rlvs_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rlvs_req_if.sink    req,
    rlvs_rsp_if.source  rsp
);
    rlvs_pkg::rlvs_cmd_t  cmd;
    rlvs_pkg::rlvs_stat_t stat;

    rlvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rlvs_datapath #(
        .MAX_RUNS    (MAX_RUNS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (req.action),
        .elem_value (req.elem_value),
        .position   (req.position),
        .range_end  (req.range_end),
        .run_value  (rsp.run_value),
        .span_len   (rsp.span_len),
        .status     (rsp.status),
        .last       (rsp.last)
    );

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != rlvs_pkg::ST_OK) |-> rsp.last)
        else $error("error response without last");

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |-> !rsp.valid)
        else $error("request taken while response pending");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.do_clear, cmd.do_append, cmd.bad_load, cmd.proj_load, cmd.emit_load}))
        else $error("competing output loads");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.status != rlvs_pkg::ST_RSVD)
        else $error("reserved status code");

endmodule
